// File: hdl/mpks_pkg.sv
// shared types and constants for the modem power key sequencer
package mpks_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned WaitW  = 16;
  localparam int unsigned CfgIdxW = 3;

  // poll modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  // sub-machine steps
  localparam logic [1:0] STEP_IDLE    = 2'd0;
  localparam logic [1:0] STEP_KEY_LOW = 2'd1;
  localparam logic [1:0] STEP_POLL    = 2'd2;
  localparam logic [1:0] STEP_UNUSED  = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_OFF_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFF_RELEASE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OFF_POLL    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ON_LOW      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ON_RELEASE  = 3'd4;

  // register reset values
  localparam logic [WaitW-1:0] OFF_LOW_RST     = 16'd2500;
  localparam logic [WaitW-1:0] OFF_RELEASE_RST = 16'd3000;
  localparam logic [WaitW-1:0] OFF_POLL_RST    = 16'd100;
  localparam logic [WaitW-1:0] ON_LOW_RST      = 16'd1000;
  localparam logic [WaitW-1:0] ON_RELEASE_RST  = 16'd5000;

  typedef struct packed {
    logic [WaitW-1:0] off_low_ms;
    logic [WaitW-1:0] off_release_ms;
    logic [WaitW-1:0] off_poll_ms;
    logic [WaitW-1:0] on_low_ms;
    logic [WaitW-1:0] on_release_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       off_step;
    logic [TimeW-1:0] off_last_ms;
    logic [WaitW-1:0] off_wait_ms;
    logic [1:0]       on_step;
    logic [TimeW-1:0] on_last_ms;
    logic [WaitW-1:0] on_wait_ms;
    logic             reset_phase;
    logic             pwkey;
  } seq_state_t;

endpackage

// File: hdl/mpks_step.sv
// next-state and result logic for one poll of the power key sequencer
module mpks_step (
  input  mpks_pkg::cfg_t              cfg,
  input  mpks_pkg::seq_state_t        cur,
  input  logic [1:0]                  mode,
  input  logic [mpks_pkg::TimeW-1:0]  now_ms,
  input  logic                        status_pin,
  output mpks_pkg::seq_state_t        nxt,
  output logic                        done
);
  import mpks_pkg::*;

  logic [TimeW-1:0] off_elapsed;
  logic [TimeW-1:0] on_elapsed;
  logic             off_act;
  logic             on_act;
  logic             run_off;
  logic             run_on;
  seq_state_t       off_res;
  seq_state_t       on_res;
  logic             off_done;
  logic             on_done;

  assign off_elapsed = now_ms - cur.off_last_ms;
  assign on_elapsed  = now_ms - cur.on_last_ms;
  assign off_act = off_elapsed >= {{(TimeW-WaitW){1'b0}}, cur.off_wait_ms};
  assign on_act  = on_elapsed >= {{(TimeW-WaitW){1'b0}}, cur.on_wait_ms};

  // off sub-machine applied to the current state
  always_comb begin
    off_res  = cur;
    off_done = 1'b0;
    if (off_act) begin
      off_res.off_last_ms = now_ms;
      case (cur.off_step)
        STEP_IDLE: begin
          off_res.pwkey       = 1'b0;
          off_res.off_wait_ms = cfg.off_low_ms;
          off_res.off_step    = STEP_KEY_LOW;
        end
        STEP_KEY_LOW: begin
          off_res.pwkey       = 1'b1;
          off_res.off_wait_ms = cfg.off_release_ms;
          off_res.off_step    = STEP_POLL;
        end
        STEP_POLL: begin
          if (!status_pin) begin
            // completion keeps the last action time
            off_res.off_step    = STEP_IDLE;
            off_res.off_wait_ms = '0;
            off_res.off_last_ms = cur.off_last_ms;
            off_done            = 1'b1;
          end else begin
            off_res.off_wait_ms = cfg.off_poll_ms;
          end
        end
        default: ;
      endcase
    end
  end

  // on sub-machine applied to the current state
  always_comb begin
    on_res  = cur;
    on_done = 1'b0;
    if (on_act) begin
      on_res.on_last_ms = now_ms;
      case (cur.on_step)
        STEP_IDLE: begin
          on_res.pwkey      = 1'b0;
          on_res.on_wait_ms = cfg.on_low_ms;
          on_res.on_step    = STEP_KEY_LOW;
        end
        STEP_KEY_LOW: begin
          on_res.pwkey      = 1'b1;
          on_res.on_wait_ms = cfg.on_release_ms;
          on_res.on_step    = STEP_POLL;
        end
        STEP_POLL: begin
          if (status_pin) begin
            on_res.on_step    = STEP_IDLE;
            on_res.on_wait_ms = '0;
            on_res.on_last_ms = cur.on_last_ms;
            on_done           = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    run_off = 1'b0;
    run_on  = 1'b0;
    unique case (mode)
      MODE_OFF:   run_off = 1'b1;
      MODE_ON:    run_on  = 1'b1;
      MODE_RESET: begin
        run_off = !cur.reset_phase;
        run_on  = cur.reset_phase;
      end
      default: ;
    endcase
  end

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    if (run_off) begin
      nxt = off_res;
      if (mode == MODE_RESET) begin
        // off finishing inside reset hands over to on without reporting done
        nxt.reset_phase = off_done;
      end else begin
        done = off_done;
      end
    end else if (run_on) begin
      nxt  = on_res;
      done = on_done;
      if (mode == MODE_RESET && on_done) begin
        nxt.reset_phase = 1'b0;
      end
    end
  end

endmodule

// File: hdl/modem_power_key_sequencer_core.sv
// top level of the modem power key sequencer: input register, poll logic, result register
// a poll accepted into the input register moves on into the result register once that
// register is free or draining, and its result beat is then offered on out_valid
// throughput: one poll per cycle while results are taken, set by the combinational timestamp
// compare and step update; a stalled result keeps the poll behind it in the input register and holds in_ready low
// reset: synchronous active-low rst_n restores the default timings, both sub-machines
// to their first step and the key to released high; no clearing pass
module modem_power_key_sequencer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mpks_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mpks_pkg::WaitW-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [mpks_pkg::TimeW-1:0]    in_now_ms,
  input  logic                          in_status_pin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_pwkey_level,
  output logic                          out_done_res
);
  import mpks_pkg::*;

  cfg_t             cfg_r;
  seq_state_t       state_r;
  seq_state_t       state_nxt;
  logic             done_nxt;

  logic             in_valid_r;
  logic [1:0]       mode_r;
  logic [TimeW-1:0] now_r;
  logic             status_r;

  logic             out_valid_r;
  logic             pwkey_r;
  logic             done_r;

  logic             adv;

  // a buffered poll moves on when the result register is free or draining
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off_low_ms     <= OFF_LOW_RST;
      cfg_r.off_release_ms <= OFF_RELEASE_RST;
      cfg_r.off_poll_ms    <= OFF_POLL_RST;
      cfg_r.on_low_ms      <= ON_LOW_RST;
      cfg_r.on_release_ms  <= ON_RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFF_LOW:     cfg_r.off_low_ms     <= cfg_wdata;
        REG_OFF_RELEASE: cfg_r.off_release_ms <= cfg_wdata;
        REG_OFF_POLL:    cfg_r.off_poll_ms    <= cfg_wdata;
        REG_ON_LOW:      cfg_r.on_low_ms      <= cfg_wdata;
        REG_ON_RELEASE:  cfg_r.on_release_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= in_mode;
      now_r    <= in_now_ms;
      status_r <= in_status_pin;
    end
  end

  mpks_step u_step (
    .cfg        (cfg_r),
    .cur        (state_r),
    .mode       (mode_r),
    .now_ms     (now_r),
    .status_pin (status_r),
    .nxt        (state_nxt),
    .done       (done_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.off_step    <= STEP_IDLE;
      state_r.off_last_ms <= '0;
      state_r.off_wait_ms <= '0;
      state_r.on_step     <= STEP_IDLE;
      state_r.on_last_ms  <= '0;
      state_r.on_wait_ms  <= '0;
      state_r.reset_phase <= 1'b0;
      state_r.pwkey       <= 1'b1;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pwkey_r <= state_nxt.pwkey;
      done_r  <= done_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pwkey_level = pwkey_r;
  assign out_done_res    = done_r;

  // sequencer state only moves with a beat leaving the input register
  assert property (@(posedge clk) disable iff (!rst_n) !adv |=> $stable(state_r))
    else $error("sequencer state changed without a poll");

  // a stalled result is held until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(pwkey_r) && $stable(done_r))
    else $error("stalled result changed");

  // the unused step code is never entered
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.off_step != STEP_UNUSED && state_r.on_step != STEP_UNUSED)
    else $error("sub-machine reached unused step");

  // the key register follows the last result delivered
  assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> pwkey_r == state_r.pwkey)
    else $error("result key level differs from held key state");

endmodule
